>>> hw/rtl/tcprc_pkg.sv
// Shared types, constants and helpers of the two-channel PI / relay controller.
package tcprc_pkg;

   localparam int unsigned OUT_LIMIT   = 200;
   localparam int unsigned FAULT_LEVEL = 850;
   localparam int unsigned FRAC_BITS   = 12;

   localparam int unsigned PV_W    = 10;
   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned HYST_W  = 8;
   localparam int unsigned DRIVE_W = 8;
   localparam int unsigned INTEG_W = 22;
   localparam int unsigned ERR_W   = PV_W + 1;
   localparam int unsigned PROD_W  = ERR_W + GAIN_W + 1;
   localparam int unsigned SUM_W   = PROD_W + 2;
   localparam int unsigned CLAMP_HI_VAL = OUT_LIMIT << FRAC_BITS;
   localparam int unsigned CLAMP_W = $clog2(CLAMP_HI_VAL + 1);

   localparam int unsigned ADDR_W = 5;
   localparam int unsigned DATA_W = 32;

   localparam logic [PV_W-1:0]    FAULT_THRESH = PV_W'(FAULT_LEVEL);
   localparam logic [DRIVE_W-1:0] DRIVE_FULL   = '1;
   localparam logic [DRIVE_W-1:0] DRIVE_OFF    = '0;
   localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'(CLAMP_HI_VAL);

   typedef enum logic [2:0] {
      REG_SETPOINT_TEMP       = 3'd0,
      REG_SETPOINT_HUMID      = 3'd1,
      REG_PROP_GAIN_TEMP      = 3'd2,
      REG_PROP_GAIN_HUMID     = 3'd3,
      REG_INTEGRAL_GAIN_TEMP  = 3'd4,
      REG_INTEGRAL_GAIN_HUMID = 3'd5,
      REG_RELAY_MODE          = 3'd6,
      REG_HYSTERESIS          = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic            channel;
      logic [PV_W-1:0] process_value;
      logic            pin_on;
   } req_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive;
      logic               sensor_fault;
   } rsp_type;

   typedef struct packed {
      logic [1:0][PV_W-1:0]   setpoint;
      logic [1:0][GAIN_W-1:0] prop_gain;
      logic [1:0][GAIN_W-1:0] integral_gain;
      logic [1:0]             relay_mode;
      logic [HYST_W-1:0]      hysteresis;
   } cfg_type;

   // Saturate a signed Q.12 value to 0 .. OUT_LIMIT.
   function automatic logic [CLAMP_W-1:0] clamp_out(input logic signed [SUM_W-1:0] v);
      logic [CLAMP_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > CLAMP_HI) begin
         r = CLAMP_HI[CLAMP_W-1:0];
      end else begin
         r = v[CLAMP_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/tcprc_csr.sv
// Configuration register file with an APB-style access port.
module tcprc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tcprc_pkg::ADDR_W-1:0]  paddr,
   input  logic [tcprc_pkg::DATA_W-1:0]  pwdata,
   output logic [tcprc_pkg::DATA_W-1:0]  prdata,
   output logic                          pready,
   output tcprc_pkg::cfg_type            cfg
);
   import tcprc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_SETPOINT_TEMP:       cfg_in.setpoint[0]      = pwdata[PV_W-1:0];
            REG_SETPOINT_HUMID:      cfg_in.setpoint[1]      = pwdata[PV_W-1:0];
            REG_PROP_GAIN_TEMP:      cfg_in.prop_gain[0]     = pwdata[GAIN_W-1:0];
            REG_PROP_GAIN_HUMID:     cfg_in.prop_gain[1]     = pwdata[GAIN_W-1:0];
            REG_INTEGRAL_GAIN_TEMP:  cfg_in.integral_gain[0] = pwdata[GAIN_W-1:0];
            REG_INTEGRAL_GAIN_HUMID: cfg_in.integral_gain[1] = pwdata[GAIN_W-1:0];
            REG_RELAY_MODE:          cfg_in.relay_mode       = pwdata[1:0];
            REG_HYSTERESIS:          cfg_in.hysteresis       = pwdata[HYST_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SETPOINT_TEMP:       prdata = DATA_W'(cfg_ff.setpoint[0]);
         REG_SETPOINT_HUMID:      prdata = DATA_W'(cfg_ff.setpoint[1]);
         REG_PROP_GAIN_TEMP:      prdata = DATA_W'(cfg_ff.prop_gain[0]);
         REG_PROP_GAIN_HUMID:     prdata = DATA_W'(cfg_ff.prop_gain[1]);
         REG_INTEGRAL_GAIN_TEMP:  prdata = DATA_W'(cfg_ff.integral_gain[0]);
         REG_INTEGRAL_GAIN_HUMID: prdata = DATA_W'(cfg_ff.integral_gain[1]);
         REG_RELAY_MODE:          prdata = DATA_W'(cfg_ff.relay_mode);
         REG_HYSTERESIS:          prdata = DATA_W'(cfg_ff.hysteresis);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/tcprc_core.sv
// Per-sample control law: fault check, relay switching and PI with anti-windup.
module tcprc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  tcprc_pkg::cfg_type   cfg,
   input  tcprc_pkg::req_type   item,
   input  logic                 update,
   output tcprc_pkg::rsp_type   rsp
);
   import tcprc_pkg::*;

   logic signed [INTEG_W-1:0] integ_ff [2];
   logic signed [INTEG_W-1:0] integ_in;

   logic                       ch;
   logic                       fault;
   logic                       relay;
   logic [PV_W-1:0]            sp;
   logic [GAIN_W-1:0]          kp;
   logic [GAIN_W-1:0]          ki;
   logic signed [ERR_W-1:0]    err;
   logic signed [PROD_W-1:0]   err_ext;
   logic signed [PROD_W-1:0]   prop_prod;
   logic signed [PROD_W-1:0]   int_prod;
   logic [CLAMP_W-1:0]         p_clamped;
   logic signed [SUM_W-1:0]    acc;
   logic signed [SUM_W-1:0]    total;
   logic [CLAMP_W-1:0]         u_clamped;
   logic signed [CLAMP_W:0]    windup;
   logic [DRIVE_W-1:0]         relay_drive;
   logic                       integ_we;

   assign ch    = item.channel;
   assign sp    = cfg.setpoint[ch];
   assign kp    = cfg.prop_gain[ch];
   assign ki    = cfg.integral_gain[ch];
   assign relay = cfg.relay_mode[ch];
   assign fault = item.process_value >= FAULT_THRESH;

   assign err     = $signed({1'b0, sp}) - $signed({1'b0, item.process_value});
   assign err_ext = PROD_W'(err);

   assign prop_prod = err_ext * $signed({{(PROD_W-GAIN_W){1'b0}}, kp});
   assign int_prod  = err_ext * $signed({{(PROD_W-GAIN_W){1'b0}}, ki});

   assign p_clamped = clamp_out(SUM_W'(prop_prod));
   assign acc       = SUM_W'(integ_ff[ch]) + SUM_W'(int_prod);
   assign total     = $signed({{(SUM_W-CLAMP_W){1'b0}}, p_clamped}) + acc;
   assign u_clamped = clamp_out(total);

   // Back-calculation: integrator keeps only what the clamped output allows.
   assign windup   = $signed({1'b0, u_clamped}) - $signed({1'b0, p_clamped});
   assign integ_in = INTEG_W'(windup);
   assign integ_we = update && !fault && !relay;

   always_comb begin
      if (err > $signed({{(ERR_W-HYST_W){1'b0}}, cfg.hysteresis})) begin
         relay_drive = DRIVE_FULL;
      end else if (err < 0) begin
         relay_drive = DRIVE_OFF;
      end else begin
         relay_drive = item.pin_on ? DRIVE_FULL : DRIVE_OFF;
      end
   end

   always_comb begin
      rsp.sensor_fault = fault;
      if (fault) begin
         rsp.drive = DRIVE_OFF;
      end else if (relay) begin
         rsp.drive = relay_drive;
      end else begin
         rsp.drive = u_clamped[FRAC_BITS +: DRIVE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff[0] <= '0;
         integ_ff[1] <= '0;
      end else if (integ_we) begin
         integ_ff[ch] <= integ_in;
      end
   end

   a_integ0_bound: assert property (@(posedge clock) disable iff (reset)
      (integ_ff[0] <= $signed(INTEG_W'(CLAMP_HI_VAL)))
      && (integ_ff[0] >= -$signed(INTEG_W'(CLAMP_HI_VAL))))
      else $error("integrator 0 outside output range");

   a_integ1_bound: assert property (@(posedge clock) disable iff (reset)
      (integ_ff[1] <= $signed(INTEG_W'(CLAMP_HI_VAL)))
      && (integ_ff[1] >= -$signed(INTEG_W'(CLAMP_HI_VAL))))
      else $error("integrator 1 outside output range");

   a_fault_hold: assert property (@(posedge clock) disable iff (reset)
      (update && fault) |=> $stable(integ_ff[0]) && $stable(integ_ff[1]))
      else $error("integrator changed on a faulted sample");

   a_pi_limit: assert property (@(posedge clock) disable iff (reset)
      (!fault && !relay) |-> (rsp.drive <= DRIVE_W'(OUT_LIMIT)))
      else $error("PI drive above output limit");

endmodule

>>> hw/rtl/two_channel_pi_relay_controller_unit.sv
// Two-channel PI / relay controller: each request passes an input register, then a response register.
// Throughput one sample per cycle while the response is not stalled; the control law runs
// in one pass between the input and response registers, integrator written at the same edge.
// Synchronous active-high reset clears all configuration registers, both
// integrators and both valid flags; the block accepts samples right after reset.
module two_channel_pi_relay_controller_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tcprc_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tcprc_pkg::rsp_type            rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tcprc_pkg::ADDR_W-1:0]  paddr,
   input  logic [tcprc_pkg::DATA_W-1:0]  pwdata,
   output logic [tcprc_pkg::DATA_W-1:0]  prdata,
   output logic                          pready
);
   import tcprc_pkg::*;

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff;
   logic    in_valid_in;
   rsp_type out_data_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type core_rsp;
   logic    out_free;
   logic    advance;
   logic    take;

   tcprc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcprc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (in_data_ff),
      .update (advance),
      .rsp    (core_rsp)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payloads while their stage stalls.
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff))
      else $error("request stalled with a free stage");

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("computed result lost");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.sensor_fault) |-> (out_data_ff.drive == DRIVE_OFF))
      else $error("faulted response with nonzero drive");

endmodule

>>> tb/two_channel_pi_relay_controller_unit_tb.sv
// Self-checking testbench for the two-channel PI / relay controller unit.
module two_channel_pi_relay_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcprc_pkg::*;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES = 400;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // Shadow copy of the controller settings and integrators
   logic [PV_W-1:0]     setpoint_cfg [2];
   logic [GAIN_W-1:0]   prop_gain_cfg [2];
   logic [GAIN_W-1:0]   integ_gain_cfg [2];
   logic [1:0]          relay_cfg;
   logic [HYST_W-1:0]   hyst_cfg;
   longint              integ_q12 [2];

   rsp_type             expected_power_q [$];
   int                  fail_count = 0;
   int unsigned         idle_cycles = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_stall_pct = 0;
   int unsigned         hold_request = 0;
   int unsigned         hold_left = 0;

   two_channel_pi_relay_controller_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   function automatic longint clamp_q12(longint v);
      longint hi;
      hi = longint'(OUT_LIMIT) << FRAC_BITS;
      if (v < 0) begin
         return 0;
      end else if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // Power level for one sample; advances the channel integrator on unfaulted PI-mode samples.
   function automatic rsp_type control_law(req_type s);
      rsp_type r;
      int      ch;
      longint  err;
      longint  p;
      longint  acc;
      longint  u;
      ch = int'(s.channel);
      r.drive = DRIVE_OFF;
      r.sensor_fault = 1'b0;
      if (s.process_value >= FAULT_LEVEL) begin
         r.sensor_fault = 1'b1;
         return r;
      end
      err = longint'(setpoint_cfg[ch]) - longint'(s.process_value);
      if (relay_cfg[ch]) begin
         if (err > longint'(hyst_cfg)) begin
            r.drive = DRIVE_FULL;
         end else if (err < 0) begin
            r.drive = DRIVE_OFF;
         end else begin
            r.drive = s.pin_on ? DRIVE_FULL : DRIVE_OFF;
         end
      end else begin
         p = clamp_q12(err * longint'(prop_gain_cfg[ch]));
         acc = integ_q12[ch] + err * longint'(integ_gain_cfg[ch]);
         u = clamp_q12(p + acc);
         integ_q12[ch] = u - p;
         r.drive = DRIVE_W'(u >>> FRAC_BITS);
      end
      return r;
   endfunction

   function automatic req_type make_sample(logic ch, int unsigned pv, logic pin);
      req_type s;
      s.channel = ch;
      s.process_value = PV_W'(pv);
      s.pin_on = pin;
      return s;
   endfunction

   // Mostly values around the setpoint, so the PI loop sees small errors too.
   function automatic req_type random_sample();
      logic        ch;
      int          pv;
      int unsigned pick;
      ch = 1'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         pv = int'(setpoint_cfg[ch]) + int'($urandom_range(0, 80)) - 40;
         if (pv < 0) pv = 0;
         if (pv > 1023) pv = 1023;
      end else if (pick < 85) begin
         pv = $urandom_range(0, FAULT_LEVEL - 1);
      end else begin
         pv = $urandom_range(0, 1023);
      end
      return make_sample(ch, pv, 1'($urandom()));
   endfunction

   function automatic logic [DATA_W-1:0] with_noise(logic [DATA_W-1:0] v, int w);
      return (DATA_W'($urandom()) << w) | v;
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return GAIN_W'($urandom_range(0, 16'h1000));
         default: return GAIN_W'($urandom());
      endcase
   endfunction

   // Called and returns at a falling edge.
   task automatic write_reg(reg_index_type idx, logic [DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_SETPOINT_TEMP:       setpoint_cfg[0] = data[PV_W-1:0];
         REG_SETPOINT_HUMID:      setpoint_cfg[1] = data[PV_W-1:0];
         REG_PROP_GAIN_TEMP:      prop_gain_cfg[0] = data[GAIN_W-1:0];
         REG_PROP_GAIN_HUMID:     prop_gain_cfg[1] = data[GAIN_W-1:0];
         REG_INTEGRAL_GAIN_TEMP:  integ_gain_cfg[0] = data[GAIN_W-1:0];
         REG_INTEGRAL_GAIN_HUMID: integ_gain_cfg[1] = data[GAIN_W-1:0];
         REG_RELAY_MODE:          relay_cfg = data[1:0];
         REG_HYSTERESIS:          hyst_cfg = data[HYST_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Called and returns at a falling edge; valid stays up for the next transaction.
   task automatic send_sample(req_type s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      expected_power_q.push_back(control_law(s));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_power_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic pick_settings();
      logic [PV_W-1:0]   sp;
      logic [HYST_W-1:0] hy;
      wait_idle();
      for (int i = 0; i < 2; i++) begin
         case ($urandom_range(0, 4))
            0: sp = '0;
            1: sp = '1;
            default: sp = PV_W'($urandom());
         endcase
         write_reg(i ? REG_SETPOINT_HUMID : REG_SETPOINT_TEMP,
                   with_noise(DATA_W'(sp), PV_W));
      end
      write_reg(REG_PROP_GAIN_TEMP, with_noise(DATA_W'(pick_gain()), GAIN_W));
      write_reg(REG_PROP_GAIN_HUMID, with_noise(DATA_W'(pick_gain()), GAIN_W));
      write_reg(REG_INTEGRAL_GAIN_TEMP, with_noise(DATA_W'(pick_gain()), GAIN_W));
      write_reg(REG_INTEGRAL_GAIN_HUMID, with_noise(DATA_W'(pick_gain()), GAIN_W));
      // favor PI mode on at least one channel
      write_reg(REG_RELAY_MODE, with_noise(DATA_W'(2'($urandom_range(0, 5) % 4)), 2));
      case ($urandom_range(0, 3))
         0: hy = '0;
         1: hy = '1;
         default: hy = HYST_W'($urandom());
      endcase
      write_reg(REG_HYSTERESIS, with_noise(DATA_W'(hy), HYST_W));
   endtask

   task automatic test_sensor_fault();
      wait_idle();
      send_sample(make_sample(1'b0, 849, 1'b0));
      send_sample(make_sample(1'b0, FAULT_LEVEL, 1'b1));
      send_sample(make_sample(1'b0, 1023, 1'b0));
      send_sample(make_sample(1'b1, 0, 1'b1));
      send_sample(make_sample(1'b1, FAULT_LEVEL, 1'b0));
      send_sample(make_sample(1'b1, 1023, 1'b1));
   endtask

   task automatic test_pi_saturation();
      wait_idle();
      write_reg(REG_SETPOINT_TEMP, 32'd1023);
      write_reg(REG_SETPOINT_HUMID, 32'd0);
      write_reg(REG_PROP_GAIN_TEMP, 32'hFFFF);
      write_reg(REG_PROP_GAIN_HUMID, 32'hFFFF);
      write_reg(REG_INTEGRAL_GAIN_TEMP, 32'hFFFF);
      write_reg(REG_INTEGRAL_GAIN_HUMID, 32'hFFFF);
      send_sample(make_sample(1'b0, 0, 1'b0));
      send_sample(make_sample(1'b0, 849, 1'b1));
      send_sample(make_sample(1'b1, 0, 1'b0));
      send_sample(make_sample(1'b1, 849, 1'b1));
   endtask

   // Small steady error winds the integrator up, then an overshoot unwinds it.
   task automatic test_integrator_windup();
      wait_idle();
      write_reg(REG_SETPOINT_TEMP, 32'd600);
      write_reg(REG_PROP_GAIN_TEMP, 32'h0800);
      write_reg(REG_INTEGRAL_GAIN_TEMP, 32'h0400);
      repeat (4) send_sample(make_sample(1'b0, 580, 1'b0));
      repeat (2) send_sample(make_sample(1'b0, 640, 1'b1));
   endtask

   task automatic test_relay_band();
      wait_idle();
      write_reg(REG_RELAY_MODE, 32'd3);
      write_reg(REG_HYSTERESIS, 32'd20);
      write_reg(REG_SETPOINT_TEMP, 32'd500);
      write_reg(REG_SETPOINT_HUMID, 32'd300);
      send_sample(make_sample(1'b0, 470, 1'b0));
      send_sample(make_sample(1'b0, 480, 1'b0));
      send_sample(make_sample(1'b0, 480, 1'b1));
      send_sample(make_sample(1'b0, 501, 1'b1));
      send_sample(make_sample(1'b0, 500, 1'b1));
      wait_idle();
      write_reg(REG_HYSTERESIS, 32'd255);
      send_sample(make_sample(1'b1, 0, 1'b0));
      send_sample(make_sample(1'b1, 100, 1'b0));
      send_sample(make_sample(1'b1, 1023, 1'b1));
   endtask

   task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct, int n);
      wait_idle();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) pick_settings();
         send_sample(random_sample());
      end
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      wait_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      pick_settings();
      hold_request = HOLD_CYCLES;
      repeat (40) send_sample(random_sample());
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left = hold_request - 1;
         hold_request = 0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_power
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_power_q.size() == 0) begin
            $error("unexpected response transaction: drive %0d sensor_fault %0d",
                   rsp_data.drive, rsp_data.sensor_fault);
            fail_count++;
         end else begin
            due = expected_power_q.pop_front();
            if (rsp_data.drive !== due.drive) begin
               $error("drive: expected %0d, actual %0d", due.drive, rsp_data.drive);
               fail_count++;
            end
            if (rsp_data.sensor_fault !== due.sensor_fault) begin
               $error("sensor_fault: expected %0d, actual %0d",
                      due.sensor_fault, rsp_data.sensor_fault);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("two_channel_pi_relay_controller_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      setpoint_cfg = '{default: '0};
      prop_gain_cfg = '{default: '0};
      integ_gain_cfg = '{default: '0};
      relay_cfg = '0;
      hyst_cfg = '0;
      integ_q12 = '{default: 0};
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_sensor_fault();
      test_pi_saturation();
      test_integrator_windup();
      test_relay_band();
      test_random_phase(0, 0, 150);
      test_random_phase(77, 0, 150);
      test_random_phase(0, 77, 150);
      test_random_phase(14, 14, 120);
      test_backpressure();
      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_power_q.size() == 0) begin
         $display("two_channel_pi_relay_controller_unit_tb: clean");
      end else begin
         $display("two_channel_pi_relay_controller_unit_tb: errors");
      end
      $finish;
   end

endmodule
